// ===== hw/rtl/tpsg_pkg.sv =====
// Shared constants, register codes and sine table builder for the torus point generator.
`timescale 1ns / 1ps

package tpsg_pkg;

  // Default geometry of the datapath
  localparam int PHASE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int RADIUS_BITS_DEF    = 10;

  // Register reset values
  localparam int MAJOR_RADIUS_RST = 230;
  localparam int MINOR_RADIUS_RST = 50;
  localparam int MAJOR_STEP_RST   = 137;
  localparam int MINOR_STEP_RST   = 1365;
  localparam int MAJOR_START_RST  = 0;
  localparam int MINOR_START_RST  = 0;

  // Sine magnitude at a full quarter turn (Q1.15)
  localparam logic [14:0] SINE_MAX = 15'h7fff;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register index
  localparam int REG_IDX_BITS = 3;
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_MAJOR_RADIUS = 3'd0,
    REG_MINOR_RADIUS = 3'd1,
    REG_MAJOR_STEP   = 3'd2,
    REG_MINOR_STEP   = 3'd3,
    REG_MAJOR_START  = 3'd4,
    REG_MINOR_START  = 3'd5
  } reg_idx_t;

  // Quarter-wave sine entry: Taylor series through x^13 in Q30, rounded to Q1.15
  function automatic logic [14:0] sine_entry(input int unsigned idx,
                                             input int unsigned addr_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          res;
    x    = (HALF_PI_Q30 * longint'(idx)) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    res = (sum + 64'sd16384) >>> 15;
    if (res > 64'sd32767) begin
      res = 64'sd32767;
    end
    return res[14:0];
  endfunction

endpackage

// ===== hw/rtl/torus_point_sweep_generator_core.sv =====
// Top level: phase accumulators, sequencer and shared multiplier for torus points.
// Each accepted input word steps through RD_CB, RD_SB, RD_CA, RD_SA, MUL_SA and FINISH,
// and a new input word is taken only in IDLE; the single table read port and the
// one shared multiplier carry the four lookups and four products in turn.
// A finished word waits in the output register; the last step stalls if it is still held.
// Reset (rst, synchronous, active high) clears the phases, loads register defaults
// and empties the sequencer and output register.
`timescale 1ns / 1ps

module torus_point_sweep_generator_core #(
  parameter int PHASE_BITS     = tpsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = tpsg_pkg::SINE_ADDR_BITS_DEF,
  parameter int RADIUS_BITS    = tpsg_pkg::RADIUS_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     restart,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       point_x,
  output logic signed [15:0]       point_y,
  output logic signed [15:0]       point_z,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tpsg_pkg::REG_IDX_BITS-1:0] cfg_index,
  input  logic [(PHASE_BITS > RADIUS_BITS ? PHASE_BITS : RADIUS_BITS)-1:0] cfg_data
);
  import tpsg_pkg::*;

  localparam int M_BITS = RADIUS_BITS + 17;   // R*2^15 + r*cos, signed
  localparam int P_BITS = M_BITS + 16;        // shared product width

  typedef enum logic [2:0] {
    IDLE, RD_CB, RD_SB, RD_CA, RD_SA, MUL_SA, FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [RADIUS_BITS-1:0] major_radius;
  logic [RADIUS_BITS-1:0] minor_radius;
  logic [PHASE_BITS-1:0]  major_step;
  logic [PHASE_BITS-1:0]  minor_step;
  logic [PHASE_BITS-1:0]  major_start;
  logic [PHASE_BITS-1:0]  minor_start;

  // Phase state and datapath
  logic [PHASE_BITS-1:0]    major_phase;
  logic [PHASE_BITS-1:0]    minor_phase;
  logic [PHASE_BITS-1:0]    rom_phase;
  logic                     rom_cos;
  logic signed [15:0]       trig;
  logic signed [M_BITS-1:0] mul_a;
  logic signed [P_BITS-1:0] prod_next;
  logic signed [P_BITS-1:0] prod;
  logic signed [M_BITS-1:0] m_reg;
  logic signed [P_BITS-1:0] z_sum;
  logic signed [P_BITS-1:0] xy_sum;
  logic signed [15:0]       z_q4;
  logic signed [15:0]       xy_q4;
  logic signed [15:0]       x_hold;
  logic signed [15:0]       z_hold;

  // Saturate a shifted value into a 16-bit coordinate
  function automatic logic signed [15:0] sat16(input logic signed [P_BITS-1:0] v);
    if (v[P_BITS-1:15] != {(P_BITS-15){v[P_BITS-1]}}) begin
      return v[P_BITS-1] ? 16'sh8000 : 16'sh7fff;
    end
    return v[15:0];
  endfunction

  assign in_ready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  // Table address select: minor angle first, then major
  assign rom_phase = (state == RD_CB || state == RD_SB) ? minor_phase : major_phase;
  assign rom_cos   = (state == RD_CB || state == RD_CA);

  tpsg_sine_rom #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk     (clk),
    .phase   (rom_phase),
    .cos_sel (rom_cos),
    .value   (trig)
  );

  // Shared multiplier: tube radius for the minor angle, ring radius m for the major
  assign mul_a     = (state == RD_SB || state == RD_CA)
                   ? $signed({17'd0, minor_radius}) : m_reg;
  assign prod_next = P_BITS'(mul_a) * P_BITS'(trig);

  // Round half up and saturate: z from Q15, x and y from Q30
  assign z_sum  = (prod + (P_BITS'(1) << 10)) >>> 11;
  assign xy_sum = (prod + (P_BITS'(1) << 25)) >>> 26;
  assign z_q4   = sat16(z_sum);
  assign xy_q4  = sat16(xy_sum);

  // Sequencer, phases, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      out_valid    <= 1'b0;
      major_phase  <= '0;
      minor_phase  <= '0;
      major_radius <= RADIUS_BITS'(MAJOR_RADIUS_RST);
      minor_radius <= RADIUS_BITS'(MINOR_RADIUS_RST);
      major_step   <= PHASE_BITS'(MAJOR_STEP_RST);
      minor_step   <= PHASE_BITS'(MINOR_STEP_RST);
      major_start  <= PHASE_BITS'(MAJOR_START_RST);
      minor_start  <= PHASE_BITS'(MINOR_START_RST);
    end else begin
      // a taken word clears valid unless the next one is loaded now
      if (out_valid && out_ready && state != FINISH) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAJOR_RADIUS: major_radius <= cfg_data[RADIUS_BITS-1:0];
          REG_MINOR_RADIUS: minor_radius <= cfg_data[RADIUS_BITS-1:0];
          REG_MAJOR_STEP:   major_step   <= cfg_data[PHASE_BITS-1:0];
          REG_MINOR_STEP:   minor_step   <= cfg_data[PHASE_BITS-1:0];
          REG_MAJOR_START:  major_start  <= cfg_data[PHASE_BITS-1:0];
          REG_MINOR_START:  minor_start  <= cfg_data[PHASE_BITS-1:0];
          default: ;
        endcase
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            if (restart) begin
              major_phase <= major_start;
              minor_phase <= minor_start;
            end else begin
              major_phase <= major_phase + major_step;
              minor_phase <= minor_phase + minor_step;
            end
            state <= RD_CB;
          end
        end
        RD_CB: begin
          state <= RD_SB;
        end
        RD_SB: begin
          prod  <= prod_next;   // r * cos(b)
          state <= RD_CA;
        end
        RD_CA: begin
          m_reg <= $signed({2'b00, major_radius, 15'd0}) + prod[M_BITS-1:0];
          prod  <= prod_next;   // r * sin(b)
          state <= RD_SA;
        end
        RD_SA: begin
          z_hold <= z_q4;
          prod   <= prod_next;  // m * cos(a)
          state  <= MUL_SA;
        end
        MUL_SA: begin
          x_hold <= xy_q4;
          prod   <= prod_next;  // m * sin(a)
          state  <= FINISH;
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            point_x   <= x_hold;
            point_y   <= xy_q4;
            point_z   <= z_hold;
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tpsg_sine_rom.sv =====
// Quarter-wave sine/cosine lookup with registered read and quadrant folding.
`timescale 1ns / 1ps

module tpsg_sine_rom #(
  parameter int PHASE_BITS     = tpsg_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = tpsg_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic [PHASE_BITS-1:0]   phase,
  input  logic                    cos_sel,
  output logic signed [15:0]      value
);
  import tpsg_pkg::*;

  localparam int QTAB     = 1 << SINE_ADDR_BITS;
  localparam int IDX_BITS = SINE_ADDR_BITS + 2;

  typedef logic [14:0] rom_t [QTAB];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < QTAB; i++) begin
      t[i] = sine_entry(i, SINE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [IDX_BITS-1:0]       idx;
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] k;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic                      full;
  logic [14:0]               rom_q;
  logic                      full_q;
  logic                      neg_q;
  logic [14:0]               mag;

  // Table index from the top of the phase word
  generate
    if (PHASE_BITS >= IDX_BITS) begin : g_trunc
      assign idx = phase[PHASE_BITS-1 -: IDX_BITS];
    end else begin : g_pad
      assign idx = {phase, {(IDX_BITS-PHASE_BITS){1'b0}}};
    end
  endgenerate

  // Cosine is one quadrant ahead; odd quadrants read the table mirrored
  assign quad = idx[IDX_BITS-1 -: 2] + {1'b0, cos_sel};
  assign k    = idx[SINE_ADDR_BITS-1:0];
  assign addr = quad[0] ? (SINE_ADDR_BITS'(0) - k) : k;
  assign full = quad[0] && (k == '0);

  // Registered table read
  always_ff @(posedge clk) begin
    rom_q  <= ROM[addr];
    full_q <= full;
    neg_q  <= quad[1];
  end

  // Apply quarter-turn endpoint and sign
  assign mag   = full_q ? SINE_MAX : rom_q;
  assign value = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ===== hw/rtl/tpsg_checker.sv =====
// Port-level checks for the torus point generator, bound to the top level.
`timescale 1ns / 1ps

module tpsg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] point_x,
  input logic signed [15:0] point_y,
  input logic signed [15:0] point_z
);

  // A held result word keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
                                && $stable(point_z))
    else $error("result word changed while stalled");

  // One word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // Reset empties the block
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A new result only comes out of work in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a word in progress");

endmodule

bind torus_point_sweep_generator_core tpsg_checker u_tpsg_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the torus point sweep generator core.
`timescale 1ns / 1ps

module tb;
  import tpsg_pkg::*;

  localparam int PB  = PHASE_BITS_DEF;
  localparam int SAB = SINE_ADDR_BITS_DEF;
  localparam int RB  = RADIUS_BITS_DEF;
  localparam int DW  = (PB > RB) ? PB : RB;
  localparam int QTAB_SIZE = 1 << SAB;
  localparam logic [PB-1:0] QUARTER_TURN = PB'(1) << (PB - 2);
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT     = 20;
  // indexes with no register behind them
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } point_t;

  // Tracks phases and config, predicts each point and checks the output words
  class point_tracker;
    int quarter_tab[QTAB_SIZE];
    logic [RB-1:0] big_r, tube_r;
    logic [PB-1:0] step_a, step_b, start_a, start_b, phase_a, phase_b;
    point_t pending_points[$];
    int mismatches;

    function new();
      longint unsigned ang, ang2, term;
      longint sum;
      for (int i = 0; i < QTAB_SIZE; i++) begin
        // sin(pi/2 * i / N) by Taylor series in Q30, then rounded to Q1.15
        ang  = (HALF_PI_Q30 * longint'(i)) >> SAB;
        ang2 = (ang * ang) >> 30;
        term = ang;
        sum  = longint'(ang);
        for (int k = 1; k < 13; k += 2) begin
          term = ((term * ang2) >> 30) / longint'((k + 1) * (k + 2));
          if ((((k + 1) / 2) % 2) == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        quarter_tab[i] = (sum > 32767) ? 32767 : int'(sum);
      end
      big_r   = RB'(MAJOR_RADIUS_RST);
      tube_r  = RB'(MINOR_RADIUS_RST);
      step_a  = PB'(MAJOR_STEP_RST);
      step_b  = PB'(MINOR_STEP_RST);
      start_a = PB'(MAJOR_START_RST);
      start_b = PB'(MINOR_START_RST);
      phase_a = '0;
      phase_b = '0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [DW-1:0] data);
      case (idx)
        REG_MAJOR_RADIUS: big_r   = data[RB-1:0];
        REG_MINOR_RADIUS: tube_r  = data[RB-1:0];
        REG_MAJOR_STEP:   step_a  = data[PB-1:0];
        REG_MINOR_STEP:   step_b  = data[PB-1:0];
        REG_MAJOR_START:  start_a = data[PB-1:0];
        REG_MINOR_START:  start_b = data[PB-1:0];
        default: ;
      endcase
    endfunction

    // Quarter-wave lookup: upper address bit negates, lower one mirrors
    function longint sine_of(logic [PB-1:0] ph);
      logic [SAB+1:0] addr;
      int kk;
      longint mag;
      addr = ph[PB-1 -: SAB+2];
      kk = int'(addr[SAB-1:0]);
      if (addr[SAB]) begin
        mag = (kk == 0) ? longint'(SINE_MAX) : longint'(quarter_tab[QTAB_SIZE - kk]);
      end else begin
        mag = longint'(quarter_tab[kk]);
      end
      return addr[SAB+1] ? -mag : mag;
    endfunction

    function longint cosine_of(logic [PB-1:0] ph);
      logic [PB-1:0] shifted;
      shifted = ph + QUARTER_TURN;
      return sine_of(shifted);
    endfunction

    // Round half up to four fraction bits, then saturate to 16 bits
    function logic [15:0] to_q4(longint v, int s);
      longint r;
      r = (v + (longint'(1) << (s - 1))) >>> s;
      if (r > 32767) begin
        r = 32767;
      end
      if (r < -32768) begin
        r = -32768;
      end
      return r[15:0];
    endfunction

    // Advance or reload the phases for an accepted word and queue its point
    function void take_tick(bit rs);
      longint cos_a, sin_a, cos_b, sin_b, m;
      point_t p;
      if (rs) begin
        phase_a = start_a;
        phase_b = start_b;
      end else begin
        phase_a = phase_a + step_a;
        phase_b = phase_b + step_b;
      end
      cos_a = cosine_of(phase_a);
      sin_a = sine_of(phase_a);
      cos_b = cosine_of(phase_b);
      sin_b = sine_of(phase_b);
      m = longint'(big_r) * 32768 + longint'(tube_r) * cos_b;
      p.x = to_q4(m * cos_a, 26);
      p.y = to_q4(m * sin_a, 26);
      p.z = to_q4(longint'(tube_r) * sin_b, 11);
      pending_points.push_back(p);
    endfunction

    function int pending_count();
      return pending_points.size();
    endfunction

    task check_point(logic signed [15:0] x, logic signed [15:0] y, logic signed [15:0] z);
      point_t want;
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d z=%0d", x, y, z));
        return;
      end
      want = pending_points.pop_front();
      if (x !== want.x) report($sformatf("point_x got %0d expected %0d", x, want.x));
      if (y !== want.y) report($sformatf("point_y got %0d expected %0d", y, want.y));
      if (z !== want.z) report($sformatf("point_z got %0d expected %0d", z, want.z));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] point_x, point_y, point_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_BITS-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  bit calm = 1'b0;
  point_tracker tracker;

  torus_point_sweep_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Output side: check accepted point words, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        tracker.check_point(point_x, point_y, point_z);
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Send one input word; valid stays up afterwards until the next call decides
  task send_word(bit rs);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    tracker.take_tick(rs);
  endtask

  task cfg_write(logic [REG_IDX_BITS-1:0] idx, logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  task cfg_done();
    cfg_valid <= 1'b0;
  endtask

  // Drain every outstanding point before touching the registers
  task settle();
    in_valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task run_burst(int n, int restart_pct);
    for (int i = 0; i < n; i++) begin
      send_word($urandom_range(99) < restart_pct);
    end
  endtask

  // Random register setting, extremes weighted in
  task random_setup();
    logic [DW-1:0] val;
    for (int i = REG_MAJOR_RADIUS; i <= REG_MINOR_START; i++) begin
      case ($urandom_range(7))
        0: val = '0;
        1: val = '1;
        default: val = DW'($urandom_range(65535));
      endcase
      if ($urandom_range(3) != 0) begin
        cfg_write(REG_IDX_BITS'(i), val);
      end
    end
    if ($urandom_range(7) == 0) begin
      cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, DW'($urandom_range(65535)));
    end
    cfg_done();
  endtask

  initial begin
    int sent;
    int phase_no;
    int len;
    int pct;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: restart then a few ticks
    send_word(1'b1);
    run_burst(3, 0);

    // largest radii, full-scale steps and starts
    settle();
    cfg_write(REG_MAJOR_RADIUS, 16'd1023);
    cfg_write(REG_MINOR_RADIUS, 16'd1023);
    cfg_write(REG_MAJOR_STEP, 16'hffff);
    cfg_write(REG_MINOR_STEP, 16'hffff);
    cfg_write(REG_MAJOR_START, 16'hffff);
    cfg_write(REG_MINOR_START, 16'hffff);
    cfg_done();
    send_word(1'b1);
    run_burst(2, 0);

    // zero radii and zero steps: the point sits at the origin
    settle();
    cfg_write(REG_MAJOR_RADIUS, 16'd0);
    cfg_write(REG_MINOR_RADIUS, 16'd0);
    cfg_write(REG_MAJOR_STEP, 16'd0);
    cfg_write(REG_MINOR_STEP, 16'd0);
    cfg_write(REG_MAJOR_START, 16'd0);
    cfg_write(REG_MINOR_START, 16'd0);
    cfg_done();
    send_word(1'b1);
    send_word(1'b0);

    // quarter-turn steps land on every quadrant boundary
    settle();
    cfg_write(REG_MAJOR_RADIUS, 16'd1023);
    cfg_write(REG_MINOR_RADIUS, 16'd1023);
    cfg_write(REG_MAJOR_STEP, 16'h4000);
    cfg_write(REG_MINOR_STEP, 16'h4000);
    cfg_done();
    send_word(1'b1);
    run_burst(4, 0);

    // radius bits above the register width are dropped; spare indexes do nothing
    settle();
    cfg_write(REG_MAJOR_RADIUS, 16'hfc05);
    cfg_write(REG_MINOR_RADIUS, 16'hffff);
    cfg_write(REG_SPARE_LO, 16'h1234);
    cfg_write(REG_SPARE_HI, 16'hffff);
    cfg_write(REG_MAJOR_STEP, 16'h0010);
    cfg_write(REG_MINOR_STEP, 16'h0fff);
    cfg_write(REG_MAJOR_START, 16'h3ff8);
    cfg_write(REG_MINOR_START, 16'h8000);
    cfg_done();
    send_word(1'b1);
    run_burst(3, 0);

    // random phases, each with its own register setting
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      random_setup();
      calm = (phase_no == 3);
      len = $urandom_range(250, 40);
      case ($urandom_range(2))
        0: pct = 2;
        1: pct = 10;
        default: pct = 50;
      endcase
      run_burst(len, pct);
      sent += len;
      phase_no++;
    end
    calm = 1'b0;

    // wait for the last points, then a few quiet cycles for strays
    in_valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
